// ===== sv/biq_pkg.sv =====
// biq_pkg: shared types, register indexes and the step table of the biquad filter
// no dependencies; imported by biq_datapath, biq_ctrl and biquad_iir_filter

package biq_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_FORM = 3'd5
  } reg_idx_t;

  typedef enum logic {
    FORM_DF1  = 1'b0,
    FORM_TDF2 = 1'b1
  } form_t;

  typedef enum logic [2:0] {
    C_B0 = 3'd0,
    C_B1 = 3'd1,
    C_B2 = 3'd2,
    C_A1 = 3'd3,
    C_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [2:0] {
    OP_X   = 3'd0,
    OP_HA  = 3'd1,
    OP_HB  = 3'd2,
    OP_Y   = 3'd3,
    OP_PO1 = 3'd4,
    OP_PO2 = 3'd5
  } opnd_sel_t;

  typedef enum logic [1:0] {
    BS_ZERO = 2'd0,
    BS_ACC  = 2'd1,
    BS_HA   = 2'd2,
    BS_HB   = 2'd3
  } base_sel_t;

  typedef enum logic [2:0] {
    DS_ACC   = 3'd0,
    DS_HA    = 3'd1,
    DS_HB    = 3'd2,
    DS_ROUND = 3'd3,
    DS_SHIFT = 3'd4
  } dest_t;

  typedef struct packed {
    logic      has_mul;
    coef_sel_t coef;
    opnd_sel_t opnd;
    base_sel_t base;
    logic      term_acc;
    logic      neg;
    dest_t     dest;
    logic      last;
  } uop_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic exec;
    uop_t uop;
  } ctl_t;

  function automatic uop_t biq_mul_op(input coef_sel_t c, input opnd_sel_t o,
                                      input base_sel_t b, input logic n,
                                      input dest_t d, input logic l);
    uop_t u;
    u.has_mul  = 1'b1;
    u.coef     = c;
    u.opnd     = o;
    u.base     = b;
    u.term_acc = 1'b0;
    u.neg      = n;
    u.dest     = d;
    u.last     = l;
    return u;
  endfunction

  function automatic uop_t biq_plain_op(input base_sel_t b, input logic t,
                                        input dest_t d, input logic l);
    uop_t u;
    u.has_mul  = 1'b0;
    u.coef     = C_B0;
    u.opnd     = OP_X;
    u.base     = b;
    u.term_acc = t;
    u.neg      = 1'b0;
    u.dest     = d;
    u.last     = l;
    return u;
  endfunction

  // step list per form: y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
  function automatic uop_t biq_uop(input form_t form, input logic [STEP_W-1:0] step);
    uop_t u;
    u = biq_plain_op(BS_ZERO, 1'b0, DS_ACC, 1'b1);
    if (form == FORM_DF1) begin
      case (step)
        3'd0: u = biq_mul_op(C_B0, OP_X,   BS_ZERO, 1'b0, DS_ACC, 1'b0);
        3'd1: u = biq_mul_op(C_B1, OP_HA,  BS_ACC,  1'b0, DS_ACC, 1'b0);
        3'd2: u = biq_mul_op(C_B2, OP_HB,  BS_ACC,  1'b0, DS_ACC, 1'b0);
        3'd3: u = biq_mul_op(C_A1, OP_PO1, BS_ACC,  1'b1, DS_ACC, 1'b0);
        3'd4: u = biq_mul_op(C_A2, OP_PO2, BS_ACC,  1'b1, DS_ACC, 1'b0);
        3'd5: u = biq_plain_op(BS_ZERO, 1'b0, DS_SHIFT, 1'b1);
        default: u = biq_plain_op(BS_ZERO, 1'b0, DS_ACC, 1'b1);
      endcase
    end else begin
      case (step)
        3'd0: u = biq_mul_op(C_B0, OP_X, BS_HA,   1'b0, DS_ACC, 1'b0);
        3'd1: u = biq_plain_op(BS_ZERO, 1'b0, DS_ROUND, 1'b0);
        3'd2: u = biq_mul_op(C_B1, OP_X, BS_ZERO, 1'b0, DS_ACC, 1'b0);
        3'd3: u = biq_mul_op(C_A1, OP_Y, BS_ACC,  1'b1, DS_ACC, 1'b0);
        3'd4: u = biq_plain_op(BS_HB, 1'b1, DS_HA, 1'b0);
        3'd5: u = biq_mul_op(C_B2, OP_X, BS_ZERO, 1'b0, DS_ACC, 1'b0);
        3'd6: u = biq_mul_op(C_A2, OP_Y, BS_ACC,  1'b1, DS_HB, 1'b1);
        default: u = biq_plain_op(BS_ZERO, 1'b0, DS_ACC, 1'b1);
      endcase
    end
    return u;
  endfunction

endpackage

// ===== sv/biq_mul.sv =====
// biq_mul: digit-serial signed multiplier, radix-4 booth digits taken msb first
// from a coefficient shift register; depends on nothing

module biq_mul #(
  parameter int OPND_BITS = 40,
  parameter int COEF_BITS = 18
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             start,
  input  logic [COEF_BITS-1:0]                             coef,
  input  logic [OPND_BITS-1:0]                             opnd,
  output logic [OPND_BITS+2*((COEF_BITS+1)/2)-1:0]         prod,
  output logic                                             done
);

  localparam int DIGITS = (COEF_BITS + 1) / 2;
  localparam int CX     = 2 * DIGITS;
  localparam int PW     = OPND_BITS + CX;
  localparam int PPW    = OPND_BITS + 2;
  localparam int CNT_W  = $clog2(DIGITS + 1);

  logic [CX:0]          sreg_r;
  logic [OPND_BITS-1:0] opnd_r;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        prod_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic [PPW-1:0]       op1;
  logic [PPW-1:0]       op2;
  logic [PPW-1:0]       pp;

  assign op1 = {{2{opnd_r[OPND_BITS-1]}}, opnd_r};
  assign op2 = {op1[PPW-2:0], 1'b0};

  always_comb begin
    case (sreg_r[CX:CX-2])
      3'b001, 3'b010: pp = op1;
      3'b011:         pp = op2;
      3'b100:         pp = -op2;
      3'b101, 3'b110: pp = -op1;
      default:        pp = '0;
    endcase
  end

  assign prod_nxt = {prod_r[PW-3:0], 2'b00} + {{(PW-PPW){pp[PPW-1]}}, pp};

  always_ff @(posedge clk) begin
    if (start) begin
      sreg_r <= {{(CX-COEF_BITS){coef[COEF_BITS-1]}}, coef, 1'b0};
      opnd_r <= opnd;
      prod_r <= '0;
    end else if (cnt_r != '0) begin
      sreg_r <= {sreg_r[CX-2:0], 2'b00};
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(DIGITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

// ===== sv/biq_datapath.sv =====
// biq_datapath: coefficient and form registers, filter history, accumulate with clamp,
// rounding and saturation; depends on biq_pkg

module biq_datapath import biq_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int ACC_BITS       = 40,
  parameter int PROD_BITS      = 58
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COEF_FRAC_BITS+1:0] cfg_data,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  ctl_t                      ctl,
  output logic [COEF_FRAC_BITS+1:0] mul_coef,
  output logic [ACC_BITS-1:0]       mul_opnd,
  input  logic [PROD_BITS-1:0]      mul_prod,
  output logic [SAMPLE_BITS-1:0]    y,
  output logic                      sat,
  output form_t                     form
);

  localparam int CB = COEF_FRAC_BITS + 2;
  localparam int SW = PROD_BITS + 1;
  localparam int QW = ACC_BITS + 1 - COEF_FRAC_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int AB = ACC_BITS;

  logic [CB-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  form_t         form_r;
  logic [SB-1:0] x_r, po1_r, po2_r, y_r;
  logic          sat_r;
  logic [AB-1:0] acc_r, ha_r, hb_r;

  logic [AB-1:0] x_ext;
  logic [SW-1:0] base;
  logic [SW-1:0] term;
  logic [SW-1:0] sum;
  logic          in_range;
  logic [AB-1:0] clamped;
  logic [AB:0]   rv;
  logic [QW-1:0] q;
  logic          q_ok;
  logic [SB-1:0] rnd;

  assign x_ext = {{(AB-SB){x_r[SB-1]}}, x_r};

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r   <= CB'(1) << COEF_FRAC_BITS;
      b1_r   <= '0;
      b2_r   <= '0;
      a1_r   <= '0;
      a2_r   <= '0;
      form_r <= FORM_DF1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:   b0_r   <= cfg_data;
        REG_B1:   b1_r   <= cfg_data;
        REG_B2:   b2_r   <= cfg_data;
        REG_A1:   a1_r   <= cfg_data;
        REG_A2:   a2_r   <= cfg_data;
        REG_FORM: form_r <= form_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctl.uop.coef)
      C_B0:    mul_coef = b0_r;
      C_B1:    mul_coef = b1_r;
      C_B2:    mul_coef = b2_r;
      C_A1:    mul_coef = a1_r;
      C_A2:    mul_coef = a2_r;
      default: mul_coef = b0_r;
    endcase
  end

  always_comb begin
    case (ctl.uop.opnd)
      OP_X:    mul_opnd = x_ext;
      OP_HA:   mul_opnd = ha_r;
      OP_HB:   mul_opnd = hb_r;
      OP_Y:    mul_opnd = {{(AB-SB){y_r[SB-1]}}, y_r};
      OP_PO1:  mul_opnd = {{(AB-SB){po1_r[SB-1]}}, po1_r};
      OP_PO2:  mul_opnd = {{(AB-SB){po2_r[SB-1]}}, po2_r};
      default: mul_opnd = x_ext;
    endcase
  end

  always_comb begin
    case (ctl.uop.base)
      BS_ZERO: base = '0;
      BS_ACC:  base = {{(SW-AB){acc_r[AB-1]}}, acc_r};
      BS_HA:   base = {{(SW-AB){ha_r[AB-1]}}, ha_r};
      BS_HB:   base = {{(SW-AB){hb_r[AB-1]}}, hb_r};
      default: base = '0;
    endcase
  end

  assign term = ctl.uop.term_acc ? {{(SW-AB){acc_r[AB-1]}}, acc_r}
                                 : {mul_prod[PROD_BITS-1], mul_prod};
  assign sum  = ctl.uop.neg ? (base - term) : (base + term);

  // clamp to the accumulator range
  assign in_range = (&sum[SW-1:AB-1]) | ~(|sum[SW-1:AB-1]);
  assign clamped  = in_range ? sum[AB-1:0] : {sum[SW-1], {(AB-1){~sum[SW-1]}}};

  // round half up, then saturate to the sample range
  assign rv   = {acc_r[AB-1], acc_r} + ((AB+1)'(1) << (COEF_FRAC_BITS - 1));
  assign q    = rv[AB:COEF_FRAC_BITS];
  assign q_ok = (&q[QW-1:SB-1]) | ~(|q[QW-1:SB-1]);
  assign rnd  = q_ok ? q[SB-1:0] : {q[QW-1], {(SB-1){~q[QW-1]}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ha_r  <= '0;
      hb_r  <= '0;
      po1_r <= '0;
      po2_r <= '0;
    end else if (ctl.clear) begin
      ha_r  <= '0;
      hb_r  <= '0;
      po1_r <= '0;
      po2_r <= '0;
    end else if (ctl.exec) begin
      case (ctl.uop.dest)
        DS_HA: ha_r <= clamped;
        DS_HB: hb_r <= clamped;
        DS_SHIFT: begin
          hb_r  <= ha_r;
          ha_r  <= x_ext;
          po2_r <= po1_r;
          po1_r <= rnd;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= sample;
    end
    if (ctl.clear) begin
      y_r   <= '0;
      sat_r <= 1'b0;
    end else if (ctl.exec) begin
      case (ctl.uop.dest)
        DS_ACC: acc_r <= clamped;
        DS_ROUND, DS_SHIFT: begin
          y_r   <= rnd;
          sat_r <= ~q_ok;
        end
        default: ;
      endcase
    end
  end

  assign y    = y_r;
  assign sat  = sat_r;
  assign form = form_r;

endmodule

// ===== sv/biq_ctrl.sv =====
// biq_ctrl: sequencer that walks the step list of the selected form, one multiply
// or combine step at a time; depends on biq_pkg

module biq_ctrl import biq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_kind,
  input  form_t form,
  input  logic  mul_done,
  input  logic  out_free,
  output logic  in_ready,
  output logic  out_load,
  output ctl_t  ctl
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_COMB  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  form_t             form_r;
  uop_t              uop;
  uop_t              uop_next;
  logic              accept;

  assign uop      = biq_uop(form_r, step_r);
  assign uop_next = biq_uop(form_r, step_r + 1'b1);
  assign accept   = (state_r == ST_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          step_nxt  = '0;
          state_nxt = in_kind ? ST_OUT : ST_START;
        end
      end
      ST_START: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_done) state_nxt = ST_COMB;
      end
      ST_COMB: begin
        if (uop.last) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = uop_next.has_mul ? ST_START : ST_COMB;
        end
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      form_r  <= FORM_DF1;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (accept) form_r <= form;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && out_free;
  assign ctl.load  = accept;
  assign ctl.clear = accept && in_kind;
  assign ctl.start = (state_r == ST_START);
  assign ctl.exec  = (state_r == ST_COMB);
  assign ctl.uop   = uop;

endmodule

// ===== sv/biquad_iir_filter.sv =====
// biquad_iir_filter: second-order iir filter, direct form 1 or transposed form 2
// depends on biq_pkg, biq_mul, biq_datapath, biq_ctrl
//
//   channel  signals                            transfer when      payload
//   in       in_tvalid/in_tready                valid & ready      tdata: sample, tuser: kind
//   out      out_tvalid/out_tready              valid & ready      tdata: filtered, tuser: saturated
//   cfg      cfg_valid/cfg_ready                valid & ready      cfg_index, cfg_data
//
// a multiply step runs DIGITS = (COEF_FRAC_BITS + 3) / 2 booth digits through the
// serial multiplier; a sample takes 5 multiply steps in either form, plus one combine
// step in direct form 1 and two in form 2
// a clear request clears the history and the last result; one sample is in work at a time
// the finished result sits in an output register; a stalled output holds the next result
// synchronous active-low reset clears history, coefficients to b0 = 1.0, form 1

module biquad_iir_filter import biq_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample
  input  logic                                 in_tuser,   // kind
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,  // filtered
  output logic                                 out_tuser,  // saturated
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [COEF_FRAC_BITS+1:0]            cfg_data
);

  localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int ACC_RAW   = SAMPLE_BITS + COEF_FRAC_BITS + 8;
  localparam int ACC_BITS  = (ACC_RAW > 62) ? 62 : ACC_RAW;
  localparam int DIGITS    = (COEF_BITS + 1) / 2;
  localparam int PROD_BITS = ACC_BITS + 2 * DIGITS;
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  ctl_t                   ctl;
  form_t                  form;
  logic                   mul_done;
  logic                   out_free;
  logic                   out_load;
  logic [COEF_BITS-1:0]   mul_coef;
  logic [ACC_BITS-1:0]    mul_opnd;
  logic [PROD_BITS-1:0]   mul_prod;
  logic [SAMPLE_BITS-1:0] y;
  logic                   sat;

  logic                   out_tvalid_r;
  logic [SAMPLE_BITS-1:0] out_data_r;
  logic                   out_sat_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  biq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .form     (form),
    .mul_done (mul_done),
    .out_free (out_free),
    .in_ready (in_tready),
    .out_load (out_load),
    .ctl      (ctl)
  );

  biq_mul #(
    .OPND_BITS (ACC_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.start),
    .coef  (mul_coef),
    .opnd  (mul_opnd),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  biq_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_BITS       (ACC_BITS),
    .PROD_BITS      (PROD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .ctl       (ctl),
    .mul_coef  (mul_coef),
    .mul_opnd  (mul_opnd),
    .mul_prod  (mul_prod),
    .y         (y),
    .sat       (sat),
    .form      (form)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y;
      out_sat_r  <= sat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tuser  = out_sat_r;

  // a transfer on the input starts work, so the input closes on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after a transfer");

  // sequencer steps never run while the input is open
  a_no_step_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.start || ctl.exec) |-> !in_tready)
    else $error("step issued while idle");

  // a clipped result sits at one end of the sample range
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[SAMPLE_BITS-1:0] == SAT_MAX) || (out_tdata[SAMPLE_BITS-1:0] == SAT_MIN))
    else $error("saturated flag without a clipped value");

endmodule
